// File: rtl/brpd_pkg.sv
`timescale 1ns / 1ps

package brpd_pkg;

   // expander port bytes for the two coil polarities and coil off
   localparam logic [7:0] PORT_TRUE  = 8'hC0;
   localparam logic [7:0] PORT_FALSE = 8'h30;
   localparam logic [7:0] PORT_OFF   = 8'h50;

   // relay state codes
   localparam logic [1:0] STATE_FALSE   = 2'd0;
   localparam logic [1:0] STATE_TRUE    = 2'd1;
   localparam logic [1:0] STATE_UNKNOWN = 2'd2;

   // reset values of the timing registers
   localparam logic [7:0] ENERGIZE_RESET = 8'd20;
   localparam logic [9:0] RECOVERY_RESET = 10'd100;

   // configuration register indexes
   localparam logic REG_ENERGIZE = 1'b0;
   localparam logic REG_RECOVERY = 1'b1;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_SET    = 2'd1,
      ACT_PULSE  = 2'd2,
      ACT_TOGGLE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_SET   = 2'd1,
      CMD_PULSE = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_SET         = 3'd1,
      PH_SET_OFF     = 3'd2,
      PH_PULSE       = 3'd3,
      PH_PULSE_OFF   = 3'd4,
      PH_REVERSE     = 3'd5,
      PH_REVERSE_OFF = 3'd6
   } phase_type;

   function automatic logic [7:0] polarity_byte(input logic lvl);
      return lvl ? PORT_TRUE : PORT_FALSE;
   endfunction

endpackage

// File: rtl/bistable_relay_pulse_driver.sv
`timescale 1ns / 1ps

// Bistable relay coil pulse driver.
// req_ channel carries one command per transfer: tick, set, pulse or toggle,
// with the wanted level and the pulse hold time. Set, pulse and toggle only
// latch a command (a newer one overwrites a pending one); ticks advance the
// energize / off / hold / reverse / recovery sequence through one down-counter.
// Every accepted item yields exactly one rsp_ transfer with the coil port
// byte, the relay state and the busy flag as they stand after the item.
// The state update and the result register are loaded at the same edge.
// Throughput is one item per cycle; the result register is the only stage,
// so req_stall rises only while a result is held by rsp_stall. A stalled
// result keeps its value.
// csr_ writes set energize_ticks (index 0) and recovery_ticks (index 1);
// csr_ready is always high. Write only while no item is in flight.
// Reset (synchronous) returns the coil to off, the relay state to unknown,
// clears any command and restores the register defaults of 20 and 100.
module bistable_relay_pulse_driver #(
   parameter int TICK_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_action,
   input  logic                  req_level,
   input  logic [15:0]           req_pulse_ticks,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_coil_port,
   output logic [1:0]            rsp_relay_state,
   output logic                  rsp_busy_res,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [9:0]            csr_wdata
);
   import brpd_pkg::*;

   // hold waits are masked to the tick width; the counter also holds recovery
   localparam int HOLD_W = (TICK_WIDTH < 16) ? TICK_WIDTH : 16;
   localparam int WAIT_W = (HOLD_W > 10) ? HOLD_W : 10;

   logic [7:0]        energize_ff;
   logic [9:0]        recovery_ff;
   phase_type         phase_ff, phase_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   cmd_type           pending_ff, pending_in;
   logic              desired_ff, desired_in;
   logic [15:0]       hold_ff, hold_in;
   logic [1:0]        known_ff, known_in;
   logic              active_ff, active_in;
   logic [7:0]        port_ff, port_in;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_coil_ff;
   logic [1:0]        rsp_state_ff;
   logic              rsp_busy_ff;

   logic              req_xfer;
   logic [WAIT_W-1:0] wait_dec;
   action_type        act;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_xfer  = req_valid & ~req_stall;
   assign act       = action_type'(req_action);
   assign wait_dec  = (wait_ff != '0) ? wait_ff - WAIT_W'(1) : wait_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         energize_ff <= ENERGIZE_RESET;
         recovery_ff <= RECOVERY_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ENERGIZE: energize_ff <= csr_wdata[7:0];
            REG_RECOVERY: recovery_ff <= csr_wdata;
            default:      energize_ff <= energize_ff;
         endcase
      end
   end

   // sequence next state for the incoming item
   always_comb begin
      phase_in   = phase_ff;
      wait_in    = wait_ff;
      pending_in = pending_ff;
      desired_in = desired_ff;
      hold_in    = hold_ff;
      known_in   = known_ff;
      active_in  = active_ff;
      port_in    = port_ff;
      unique case (act)
         ACT_TICK: begin
            if (active_ff) begin
               wait_in = wait_dec;
               if (wait_dec == '0) begin
                  unique case (phase_ff)
                     PH_SET, PH_PULSE: begin
                        port_in  = polarity_byte(desired_ff);
                        known_in = {1'b0, desired_ff};
                        phase_in = (phase_ff == PH_SET) ? PH_SET_OFF : PH_PULSE_OFF;
                        wait_in  = WAIT_W'(energize_ff);
                     end
                     PH_SET_OFF, PH_REVERSE_OFF: begin
                        port_in  = PORT_OFF;
                        phase_in = PH_IDLE;
                        wait_in  = WAIT_W'(recovery_ff);
                     end
                     PH_PULSE_OFF: begin
                        port_in  = PORT_OFF;
                        phase_in = PH_REVERSE;
                        wait_in  = WAIT_W'(hold_ff[HOLD_W-1:0]);
                     end
                     PH_REVERSE: begin
                        known_in = (known_ff == STATE_TRUE) ? STATE_FALSE : STATE_TRUE;
                        port_in  = polarity_byte(known_ff != STATE_TRUE);
                        phase_in = PH_REVERSE_OFF;
                        wait_in  = WAIT_W'(energize_ff);
                     end
                     default: begin
                        // idle: start the pending command's energize step at once
                        pending_in = CMD_NONE;
                        if (pending_ff == CMD_SET || pending_ff == CMD_PULSE) begin
                           port_in  = polarity_byte(desired_ff);
                           known_in = {1'b0, desired_ff};
                           phase_in = (pending_ff == CMD_SET) ? PH_SET_OFF : PH_PULSE_OFF;
                           wait_in  = WAIT_W'(energize_ff);
                        end else begin
                           phase_in  = PH_IDLE;
                           active_in = 1'b0;
                        end
                     end
                  endcase
               end
            end
         end
         ACT_SET: begin
            pending_in = CMD_SET;
            desired_in = req_level;
            if (!active_ff) begin
               active_in = 1'b1;
               wait_in   = '0;
            end
         end
         ACT_PULSE: begin
            hold_in    = req_pulse_ticks;
            pending_in = CMD_PULSE;
            desired_in = req_level;
            if (!active_ff) begin
               active_in = 1'b1;
               wait_in   = '0;
            end
         end
         default: begin
            // toggle is ignored while the relay state is unknown
            if (known_ff == STATE_FALSE || known_ff == STATE_TRUE) begin
               pending_in = CMD_SET;
               desired_in = (known_ff == STATE_FALSE);
               if (!active_ff) begin
                  active_in = 1'b1;
                  wait_in   = '0;
               end
            end
         end
      endcase
   end

   // sequence state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         wait_ff    <= '0;
         pending_ff <= CMD_NONE;
         desired_ff <= 1'b0;
         hold_ff    <= '0;
         known_ff   <= STATE_UNKNOWN;
         active_ff  <= 1'b0;
         port_ff    <= PORT_OFF;
      end else if (req_xfer) begin
         phase_ff   <= phase_in;
         wait_ff    <= wait_in;
         pending_ff <= pending_in;
         desired_ff <= desired_in;
         hold_ff    <= hold_in;
         known_ff   <= known_in;
         active_ff  <= active_in;
         port_ff    <= port_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_coil_ff  <= port_in;
         rsp_state_ff <= known_in;
         rsp_busy_ff  <= active_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coil_port   = rsp_coil_ff;
   assign rsp_relay_state = rsp_state_ff;
   assign rsp_busy_res    = rsp_busy_ff;

endmodule

// File: rtl/brpd_checker.sv
`timescale 1ns / 1ps

module brpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_coil_port,
   input logic [1:0] rsp_relay_state,
   input logic       rsp_busy_res
);
   import brpd_pkg::*;

   // a stalled result stays and keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_coil_port)
         && $stable(rsp_relay_state) && $stable(rsp_busy_res))
      else $error("stalled result changed");

   // coil byte is one of the three legal patterns
   a_port_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_coil_port == PORT_TRUE || rsp_coil_port == PORT_FALSE
         || rsp_coil_port == PORT_OFF))
      else $error("illegal coil byte");

   // coil is never driven before the relay state is known
   a_unknown_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_relay_state == STATE_UNKNOWN |-> rsp_coil_port == PORT_OFF)
      else $error("coil driven with unknown state");

   // an idle driver leaves the coil off
   a_idle_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_coil_port == PORT_OFF)
      else $error("coil driven while not busy");

   // no result directly out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind bistable_relay_pulse_driver brpd_checker u_brpd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_coil_port   (rsp_coil_port),
   .rsp_relay_state (rsp_relay_state),
   .rsp_busy_res    (rsp_busy_res)
);
